// ----- rtl/cct_pkg.sv -----
// Types, constants and calendar functions shared by the calendar clock files.
`default_nettype none

package cct_pkg;

  // Request codes carried in req_type.
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // Largest legal value of each counting field.
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd12;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;

  // Reset time: the first second of the year 2000.
  localparam logic [15:0] RST_YEAR  = 16'd2000;
  localparam logic [3:0]  RST_MONTH = 4'd1;
  localparam logic [4:0]  RST_DAY   = 5'd1;

  // Divisibility by 25 of a 16-bit year: multiply by the inverse of 25 modulo
  // 2^16; the product stays at or below floor(65535 / 25) exactly for multiples.
  localparam logic [15:0] INV25     = 16'd23593;
  localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } time_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] load_year;
    logic [3:0]  load_month;
    logic [4:0]  load_day;
    logic [4:0]  load_hour;
    logic [5:0]  load_minute;
    logic [5:0]  load_second;
  } in_item_t;

  typedef struct packed {
    logic [15:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        load_error;
  } out_item_t;

  // Days in a common year; codes outside 1 to 12 give zero.
  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1:    d = 5'd31;
      4'd2:    d = 5'd28;
      4'd3:    d = 5'd31;
      4'd4:    d = 5'd30;
      4'd5:    d = 5'd31;
      4'd6:    d = 5'd30;
      4'd7:    d = 5'd31;
      4'd8:    d = 5'd31;
      4'd9:    d = 5'd30;
      4'd10:   d = 5'd31;
      4'd11:   d = 5'd30;
      4'd12:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Divisible by 4 and not by 100, or divisible by 400 (16 and 25).
  function automatic logic is_leap(input logic [15:0] y);
    logic [15:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m, input logic [15:0] y);
    logic [4:0] len;
    len = month_days(m);
    if ((m == MONTH_FEB) && is_leap(y)) begin
      len = FEB_LEAP_DAYS;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cct_channels.sv -----
// Valid/ready channel interfaces for the request and result beats.
`default_nettype none

interface cct_in_if;
  logic              valid;
  logic              ready;
  cct_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cct_out_if;
  logic               valid;
  logic               ready;
  cct_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/cct_next_time.sv -----
// Next-time logic: one-second carry chain and checked load of all fields.
`default_nettype none

module cct_next_time (
  input  cct_pkg::time_t    cur_i,
  input  cct_pkg::in_item_t item_i,
  output cct_pkg::time_t    nxt_o,
  output logic              err_o
);

  cct_pkg::time_t loaded;
  logic [4:0]     cur_len;
  logic [4:0]     load_len;
  logic           load_ok;

  assign cur_len  = cct_pkg::month_length(cur_i.month, cur_i.year);
  assign load_len = cct_pkg::month_length(item_i.load_month, item_i.load_year);

  assign loaded.year   = item_i.load_year;
  assign loaded.month  = item_i.load_month;
  assign loaded.day    = item_i.load_day;
  assign loaded.hour   = item_i.load_hour;
  assign loaded.minute = item_i.load_minute;
  assign loaded.second = item_i.load_second;

  // The day is judged against the month and year being loaded.
  assign load_ok = (item_i.load_month >= 4'd1) && (item_i.load_month <= cct_pkg::MONTH_MAX)
                && (item_i.load_hour <= cct_pkg::HOUR_MAX)
                && (item_i.load_minute <= cct_pkg::MIN_MAX)
                && (item_i.load_second <= cct_pkg::SEC_MAX)
                && (item_i.load_day >= 5'd1) && (item_i.load_day <= load_len);

  always_comb begin
    nxt_o = cur_i;
    err_o = 1'b0;
    if (item_i.req_type == cct_pkg::REQ_TICK) begin
      if (cur_i.second < cct_pkg::SEC_MAX) begin
        nxt_o.second = cur_i.second + 6'd1;
      end else begin
        nxt_o.second = 6'd0;
        if (cur_i.minute < cct_pkg::MIN_MAX) begin
          nxt_o.minute = cur_i.minute + 6'd1;
        end else begin
          nxt_o.minute = 6'd0;
          if (cur_i.hour < cct_pkg::HOUR_MAX) begin
            nxt_o.hour = cur_i.hour + 5'd1;
          end else begin
            nxt_o.hour = 5'd0;
            if (cur_i.day < cur_len) begin
              nxt_o.day = cur_i.day + 5'd1;
            end else begin
              nxt_o.day = 5'd1;
              if (cur_i.month < cct_pkg::MONTH_MAX) begin
                nxt_o.month = cur_i.month + 4'd1;
              end else begin
                nxt_o.month = 4'd1;
                // The year wraps to zero after 65535.
                nxt_o.year  = cur_i.year + 16'd1;
              end
            end
          end
        end
      end
    end else begin
      if (load_ok) begin
        nxt_o = loaded;
      end else begin
        err_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/calendar_clock_tick_top.sv -----
// Gregorian calendar clock: request channel in, time-and-status result channel out.
//
// Every request beat on in_i produces exactly one result beat on out_o. A tick
// request advances the held time by one second, carrying through minute, hour,
// day (month length from a fixed table, February with 29 days in a leap year),
// month and year; the year wraps from 65535 to 0. A load request checks all six
// fields and takes them all, or rejects them all with load_error set and the
// time left as it was.
//
// The next time is formed combinationally from the held time and the request, so
// the result appears on out_o in the cycle after its request beat is taken. A new
// request is accepted every cycle while the result register is empty or being
// drained; when the receiver stalls with a result pending, in_i.ready drops
// until that result is taken, so nothing is lost or repeated.
//
// Reset sets the time to 2000-01-01 00:00:00 and empties the result register.
`default_nettype none

module calendar_clock_tick_top (
  input  logic     clk_i,
  input  logic     rst_ni,
  cct_in_if.sink   in_i,
  cct_out_if.source out_o
);

  cct_pkg::time_t     time_q;
  cct_pkg::time_t     time_d;
  logic               err_d;
  cct_pkg::out_item_t res_q;
  logic               res_valid_q;
  logic               in_acc;

  assign in_i.ready = !res_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  cct_next_time u_next (
    .cur_i  (time_q),
    .item_i (in_i.data),
    .nxt_o  (time_d),
    .err_o  (err_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.year   <= cct_pkg::RST_YEAR;
      time_q.month  <= cct_pkg::RST_MONTH;
      time_q.day    <= cct_pkg::RST_DAY;
      time_q.hour   <= 5'd0;
      time_q.minute <= 6'd0;
      time_q.second <= 6'd0;
      res_valid_q   <= 1'b0;
    end else begin
      if (in_acc) begin
        time_q      <= time_d;
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q.year_out   <= time_d.year;
      res_q.month_out  <= time_d.month;
      res_q.day_out    <= time_d.day;
      res_q.hour_out   <= time_d.hour;
      res_q.minute_out <= time_d.minute;
      res_q.second_out <= time_d.second;
      res_q.load_error <= err_d;
    end
  end

  assign out_o.valid = res_valid_q;
  assign out_o.data  = res_q;

  // The held time never leaves the legal ranges of its fields.
  a_time_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q.month >= 4'd1) && (time_q.month <= cct_pkg::MONTH_MAX)
    && (time_q.day >= 5'd1) && (time_q.hour <= cct_pkg::HOUR_MAX)
    && (time_q.minute <= cct_pkg::MIN_MAX) && (time_q.second <= cct_pkg::SEC_MAX))
    else $error("held time out of range");

  // A rejected load leaves the time as it was.
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && err_d |=> (time_q == $past(time_q)) && out_o.data.load_error)
    else $error("rejected load changed the time");

  // A tick below the top of the minute just steps the second.
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.data.req_type == cct_pkg::REQ_TICK)
    && (time_q.second < cct_pkg::SEC_MAX)
    |=> (out_o.data.second_out == $past(time_q.second) + 6'd1)
    && (out_o.data.minute_out == $past(time_q.minute)) && !out_o.data.load_error)
    else $error("tick did not step the second");

  // The result shown is the time that is now held.
  a_result_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_o.valid && (out_o.data.year_out == time_q.year)
    && (out_o.data.day_out == time_q.day) && (out_o.data.second_out == time_q.second))
    else $error("result does not match held time");

endmodule

`default_nettype wire
